// File: src/nbns_name_query_responder_top_assert.svh
// ----------------------------------------------------------------------------
// NBNS responder assertion macros
// Shorthand for the clocked checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef NBNS_NAME_QUERY_RESPONDER_TOP_ASSERT_SVH
`define NBNS_NAME_QUERY_RESPONDER_TOP_ASSERT_SVH

// Same-cycle implication on the block clock, disabled during reset.
`define NNQR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on the block clock, disabled during reset.
`define NNQR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/nnqr_pkg.sv
// ----------------------------------------------------------------------------
// NBNS responder package
// Shared types and constants of the name query responder.
// ----------------------------------------------------------------------------
`default_nettype none

package nnqr_pkg;

  // Message geometry.
  localparam int NAME_CHARS   = 16;
  localparam int QUESTION_LEN = 38;
  localparam int STORE_DEPTH  = 128;
  localparam int STORE_AW     = 7;

  // Parser phase codes.
  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_QUESTION = 2'd1;
  localparam logic [1:0] PH_IGNORE   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NAME_LO = 2'd0;
  localparam logic [1:0] CFG_NAME_HI = 2'd1;
  localparam logic [1:0] CFG_IPV4    = 2'd2;

  // Byte positions inside the header and a question.
  localparam logic [5:0] HDR_LAST_POS = 6'd11;
  localparam logic [5:0] Q_NAME_FIRST = 6'd1;
  localparam logic [5:0] Q_NAME_LAST  = 6'd32;
  localparam logic [5:0] Q_LAST_POS   = 6'd37;

  // Byte positions inside the answer.
  localparam logic [5:0] ANS_Q_FIRST  = 6'd12;
  localparam logic [5:0] ANS_Q_LAST   = 6'd49;
  localparam logic [5:0] ANS_LAST_POS = 6'd61;

  // Header flag bytes expected in a query.
  localparam logic [7:0] QUERY_FLAGS_B2 = 8'h01;
  localparam logic [7:0] QUERY_FLAGS_B3 = 8'h10;

  // Fixed answer fields.
  localparam logic [7:0]  ANS_FLAGS    = 8'h85;
  localparam logic [7:0]  ANS_COUNT_LO = 8'h01;
  localparam logic [31:0] ANS_TTL      = 32'h000493E0;
  localparam logic [7:0]  ANS_RDLENGTH = 8'd6;

  // Characters used by the name decoder.
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CASE_STEP  = 8'h20;

  // Answer request from the parser to the answer sequencer.
  typedef struct packed {
    logic        start;
    logic        bank;
    logic [15:0] xid;
    logic [31:0] rip;
    logic [15:0] rport;
  } ans_req_t;

  // Fold ASCII upper case letters to lower case.
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_A && c <= CHAR_Z) begin
      r = c + CASE_STEP;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/nnqr_in_if.sv
// ----------------------------------------------------------------------------
// NBNS responder input channel
// Valid/ready channel that carries received datagram payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnqr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        end_of_datagram;
  logic [31:0] sender_ip;
  logic [15:0] sender_port;

  modport source (
    output valid, payload_byte, end_of_datagram, sender_ip, sender_port,
    input  ready
  );
  modport sink (
    input  valid, payload_byte, end_of_datagram, sender_ip, sender_port,
    output ready
  );
endinterface

`default_nettype wire

// File: src/nnqr_out_if.sv
// ----------------------------------------------------------------------------
// NBNS responder result channel
// Valid/ready channel that carries the bytes of answer datagrams.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnqr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  answer_byte;
  logic        answer_last;
  logic [31:0] reply_ip;
  logic [15:0] reply_port;

  modport source (
    output valid, answer_byte, answer_last, reply_ip, reply_port,
    input  ready
  );
  modport sink (
    input  valid, answer_byte, answer_last, reply_ip, reply_port,
    output ready
  );
endinterface

`default_nettype wire

// File: src/nnqr_cfg_if.sv
// ----------------------------------------------------------------------------
// NBNS responder configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnqr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/nnqr_ram.sv
// ----------------------------------------------------------------------------
// NBNS responder RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module nnqr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: src/nnqr_parser.sv
// ----------------------------------------------------------------------------
// NBNS responder parser
// Walks the header and questions, stores question bytes and matches names.
// ----------------------------------------------------------------------------
`default_nettype none

module nnqr_parser import nnqr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  nnqr_in_if.sink             in_chan,
  input  logic [127:0]        host_name,
  input  logic                emit_busy,
  output ans_req_t            ans_req,
  output logic                st_wr_en,
  output logic [STORE_AW-1:0] st_wr_addr,
  output logic [7:0]          st_wr_data
);

  logic [1:0]  phase_r, phase_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [15:0] xid_r, xid_nxt;
  logic [15:0] qleft_r, qleft_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic        eq_r, eq_nxt;
  logic        term_r, term_nxt;
  logic        bank_r, bank_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [7:0]  hi_off;
  logic [7:0]  dec_raw;
  logic [7:0]  dec_chr;
  logic [4:0]  char_pos;
  logic [3:0]  ci;
  logic [7:0]  host_chr;
  logic [7:0]  x_fold;
  logic [7:0]  y_fold;

  // Intake stalls only when a matching question would finish while the
  // sequencer still holds the previous answer.
  assign in_chan.ready = !(phase_r == PH_QUESTION && pos_r == Q_LAST_POS && eq_r
                           && emit_busy);
  assign accept = in_chan.valid && in_chan.ready;
  assign b      = in_chan.payload_byte;

  // Half-ASCII decode of the current pair and host name lookup.
  assign hi_off   = hi_r - CHAR_A;
  assign dec_raw  = {hi_off[3:0], 4'h0} + b - CHAR_A;
  assign dec_chr  = (dec_raw == CHAR_SPACE) ? 8'h00 : dec_raw;
  assign char_pos = pos_r[5:1] - 5'd1;
  assign ci       = char_pos[3:0];
  assign host_chr = host_name[{ci, 3'b000} +: 8];
  assign x_fold   = fold_char(dec_chr);
  assign y_fold   = fold_char(host_chr);

  // Question bytes go into the bank that is not being answered.
  assign st_wr_en   = accept && phase_r == PH_QUESTION;
  assign st_wr_addr = {bank_r, pos_r};
  assign st_wr_data = b;

  // Next-state logic of the parser.
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    xid_nxt   = xid_r;
    qleft_nxt = qleft_r;
    hi_nxt    = hi_r;
    eq_nxt    = eq_r;
    term_nxt  = term_r;
    bank_nxt  = bank_r;
    ans_req   = '0;
    if (accept) begin
      case (phase_r)
        PH_HEADER: begin
          case (pos_r)
            6'd0: xid_nxt[7:0] = b;
            6'd1: xid_nxt[15:8] = b;
            6'd2: if (b != QUERY_FLAGS_B2) phase_nxt = PH_IGNORE;
            6'd3: if (b != QUERY_FLAGS_B3) phase_nxt = PH_IGNORE;
            6'd4: qleft_nxt = {b, 8'h00};
            6'd5: qleft_nxt = {qleft_r[15:8], b};
            default: ;
          endcase
          if (phase_nxt == PH_HEADER) begin
            if (pos_r >= HDR_LAST_POS) begin
              if (qleft_nxt == 16'd0) begin
                phase_nxt = PH_IGNORE;
              end else begin
                phase_nxt = PH_QUESTION;
                pos_nxt   = '0;
                hi_nxt    = '0;
                eq_nxt    = 1'b1;
                term_nxt  = 1'b0;
              end
            end else begin
              pos_nxt = pos_r + 6'd1;
            end
          end
        end
        PH_QUESTION: begin
          // Name pairs: odd positions hold the high half, even ones complete.
          if (pos_r >= Q_NAME_FIRST && pos_r <= Q_NAME_LAST) begin
            if (pos_r[0]) begin
              hi_nxt = b;
            end else if (eq_r && !term_r) begin
              if (x_fold != y_fold) begin
                eq_nxt = 1'b0;
              end else if (x_fold == 8'h00) begin
                term_nxt = 1'b1;
              end
            end
          end
          if (pos_r == Q_LAST_POS) begin
            if (eq_r) begin
              ans_req.start = 1'b1;
              ans_req.bank  = bank_r;
              ans_req.xid   = xid_r;
              ans_req.rip   = in_chan.sender_ip;
              ans_req.rport = in_chan.sender_port;
              bank_nxt      = !bank_r;
            end
            qleft_nxt = qleft_r - 16'd1;
            if (qleft_nxt == 16'd0) begin
              phase_nxt = PH_IGNORE;
            end
            pos_nxt  = '0;
            hi_nxt   = '0;
            eq_nxt   = 1'b1;
            term_nxt = 1'b0;
          end else begin
            pos_nxt = pos_r + 6'd1;
          end
        end
        default: ;
      endcase
      // The datagram end always returns the parser to the header.
      if (in_chan.end_of_datagram) begin
        phase_nxt = PH_HEADER;
        pos_nxt   = '0;
        hi_nxt    = '0;
        eq_nxt    = 1'b1;
        term_nxt  = 1'b0;
      end
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      xid_r   <= '0;
      qleft_r <= '0;
      hi_r    <= '0;
      eq_r    <= 1'b1;
      term_r  <= 1'b0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      xid_r   <= xid_nxt;
      qleft_r <= qleft_nxt;
      hi_r    <= hi_nxt;
      eq_r    <= eq_nxt;
      term_r  <= term_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/nnqr_emitter.sv
// ----------------------------------------------------------------------------
// NBNS responder answer sequencer
// Streams the 62-byte answer, reading the copied question from the store.
// ----------------------------------------------------------------------------
`default_nettype none

module nnqr_emitter import nnqr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ans_req_t            ans_req,
  input  logic [31:0]         host_ipv4,
  output logic                emit_busy,
  output logic                st_rd_en,
  output logic [STORE_AW-1:0] st_rd_addr,
  input  logic [7:0]          st_rd_data,
  nnqr_out_if.source          out_chan
);

  logic        active_r;
  logic [5:0]  k_r;
  logic        bank_r;
  logic [15:0] xid_r;
  logic [31:0] rip_r;
  logic [15:0] rport_r;
  logic        s2_valid_r;
  logic [5:0]  s2_k_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic [31:0] out_ip_r;
  logic [15:0] out_port_r;

  logic        adv;
  logic [5:0]  q_off;
  logic [7:0]  byte_sel;

  // The whole pipeline moves when the output register is free or drained.
  assign adv       = !out_valid_r || out_chan.ready;
  assign emit_busy = active_r || s2_valid_r;

  // Store read for the copied question section.
  assign q_off      = k_r - ANS_Q_FIRST;
  assign st_rd_en   = adv;
  assign st_rd_addr = {bank_r, q_off};

  // Answer byte for the position in the second stage.
  always_comb begin
    case (s2_k_r) inside
      [ANS_Q_FIRST:ANS_Q_LAST]: byte_sel = st_rd_data;
      6'd0:    byte_sel = xid_r[7:0];
      6'd1:    byte_sel = xid_r[15:8];
      6'd2:    byte_sel = ANS_FLAGS;
      6'd7:    byte_sel = ANS_COUNT_LO;
      6'd50:   byte_sel = ANS_TTL[31:24];
      6'd51:   byte_sel = ANS_TTL[23:16];
      6'd52:   byte_sel = ANS_TTL[15:8];
      6'd53:   byte_sel = ANS_TTL[7:0];
      6'd55:   byte_sel = ANS_RDLENGTH;
      6'd58:   byte_sel = host_ipv4[31:24];
      6'd59:   byte_sel = host_ipv4[23:16];
      6'd60:   byte_sel = host_ipv4[15:8];
      6'd61:   byte_sel = host_ipv4[7:0];
      default: byte_sel = 8'h00;
    endcase
  end

  // Control: sequencer activity and stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s2_valid_r  <= active_r;
        out_valid_r <= s2_valid_r;
        if (active_r && k_r == ANS_LAST_POS) begin
          active_r <= 1'b0;
        end
      end
      if (ans_req.start) begin
        active_r <= 1'b1;
      end
    end
  end

  // Datapath: position counter, request snapshot and output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_k_r     <= k_r;
      out_byte_r <= byte_sel;
      out_last_r <= (s2_k_r == ANS_LAST_POS);
      out_ip_r   <= rip_r;
      out_port_r <= rport_r;
      if (active_r) begin
        k_r <= k_r + 6'd1;
      end
    end
    if (ans_req.start) begin
      k_r     <= '0;
      bank_r  <= ans_req.bank;
      xid_r   <= ans_req.xid;
      rip_r   <= ans_req.rip;
      rport_r <= ans_req.rport;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.answer_byte = out_byte_r;
  assign out_chan.answer_last = out_last_r;
  assign out_chan.reply_ip    = out_ip_r;
  assign out_chan.reply_port  = out_port_r;

endmodule

`default_nettype wire

// File: src/nbns_name_query_responder_top.sv
// ----------------------------------------------------------------------------
// NBNS name query responder
// Parses NetBIOS name queries byte by byte and emits matching answers.
// ----------------------------------------------------------------------------
// The block takes one payload byte per cycle unless the input stalls. Every
// question is written into 38 bytes of one of two 64-byte banks of a
// question store RAM. A question whose name matches the configured host name
// launches a 62-byte answer. A single sequencer streams it out of that bank at
// one byte per cycle while the result side takes bytes, and the next question
// goes into the other bank. The first answer byte is offered once the request
// has passed the position register, second stage and output register. The
// sequencer is busy until the last byte enters the output register. The input
// stalls only on the last byte of a matching question while the previous
// answer is still being sequenced, as when such questions follow each other.
// The store needs no clearing pass after reset. Configuration must be written
// while the block is idle; the block itself does not enforce this.
`default_nettype none

`include "nbns_name_query_responder_top_assert.svh"

module nbns_name_query_responder_top import nnqr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  nnqr_in_if.sink    in_chan,
  nnqr_out_if.source out_chan,
  nnqr_cfg_if.sink   cfg_chan
);

  logic [63:0]         name_lo_r;
  logic [63:0]         name_hi_r;
  logic [31:0]         ipv4_r;

  ans_req_t            ans_req;
  logic                emit_busy;
  logic                st_wr_en;
  logic [STORE_AW-1:0] st_wr_addr;
  logic [7:0]          st_wr_data;
  logic                st_rd_en;
  logic [STORE_AW-1:0] st_rd_addr;
  logic [7:0]          st_rd_data;

  // Configuration registers; every write transaction is taken at once.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_lo_r <= '0;
      name_hi_r <= '0;
      ipv4_r    <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_NAME_LO: name_lo_r <= cfg_chan.data;
        CFG_NAME_HI: name_hi_r <= cfg_chan.data;
        CFG_IPV4:    ipv4_r    <= cfg_chan.data[31:0];
        default: ;
      endcase
    end
  end

  // Header and question parser.
  nnqr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .host_name  ({name_hi_r, name_lo_r}),
    .emit_busy  (emit_busy),
    .ans_req    (ans_req),
    .st_wr_en   (st_wr_en),
    .st_wr_addr (st_wr_addr),
    .st_wr_data (st_wr_data)
  );

  // Two-bank question store.
  nnqr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // Answer sequencer.
  nnqr_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .ans_req    (ans_req),
    .host_ipv4  (ipv4_r),
    .emit_busy  (emit_busy),
    .st_rd_en   (st_rd_en),
    .st_rd_addr (st_rd_addr),
    .st_rd_data (st_rd_data),
    .out_chan   (out_chan)
  );

  // Checks on the parser to sequencer hand-off.
  `NNQR_ASSERT_IMP(a_start_when_idle, ans_req.start, !emit_busy, "answer started while busy")
  `NNQR_ASSERT_NXT(a_busy_after_start, ans_req.start, emit_busy, "sequencer idle after start")
  `NNQR_ASSERT_IMP(a_stall_only_busy, !in_chan.ready, emit_busy, "input stalled while idle")

endmodule

`default_nettype wire
